// ===== hw/rtl/mwf_pkg.sv =====
package mwf_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ROW_W      = 12;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned WID_W      = 11;
  localparam int unsigned HGT_W      = 13;
  localparam int unsigned CFG_W      = 13;
  localparam int unsigned WIN        = 3;
  localparam int unsigned WIN_N      = WIN * WIN;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned MIN_SIZE   = 3;
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [WID_W-1:0] WIDTH_RST  = WID_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RST = HGT_W'(480);

  typedef enum logic [0:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

  typedef struct packed {
    win_t             win;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } entry_t;

  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } tri_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t min3(pix_t a, pix_t b, pix_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic pix_t max3(pix_t a, pix_t b, pix_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic tri_t sort3(pix_t a, pix_t b, pix_t c);
    tri_t t;
    t.lo  = min3(a, b, c);
    t.mid = med3(a, b, c);
    t.hi  = max3(a, b, c);
    return t;
  endfunction

endpackage

// ===== hw/rtl/mwf_intf.sv =====
interface mwf_pix_if;
  logic                       valid;
  logic                       ready;
  logic [mwf_pkg::PIX_W-1:0]  pixel;
  logic                       frame_start;

  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface mwf_res_if;
  logic                       valid;
  logic                       ready;
  logic [mwf_pkg::ROW_W-1:0]  out_row;
  logic [mwf_pkg::COL_W-1:0]  out_col;
  logic [mwf_pkg::PIX_W-1:0]  median_value;
  logic                       frame_last;

  modport source (output valid, out_row, out_col, median_value, frame_last, input ready);
  modport sink   (input valid, out_row, out_col, median_value, frame_last, output ready);
endinterface

// ===== hw/rtl/mwf_front.sv =====
module mwf_front #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mwf_pix_if.sink                       pix_if,
  input  logic [mwf_pkg::WID_W-1:0]     image_width_i,
  input  logic [mwf_pkg::HGT_W-1:0]     image_height_i,
  input  logic [mwf_pkg::Q_CNT_W-1:0]   q_count_i,
  output logic                          q_push_o,
  output mwf_pkg::entry_t               q_entry_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned CW = mwf_pkg::Q_CNT_W + 1;

  mwf_pkg::pix_t upper_mem [MAX_WIDTH];
  mwf_pkg::pix_t lower_mem [MAX_WIDTH];

  logic [mwf_pkg::COL_W-1:0] col_q, col_d, cur_col;
  logic [mwf_pkg::ROW_W-1:0] row_q, row_d, cur_row;
  logic [AW-1:0]             addr;
  logic [mwf_pkg::HGT_W-1:0] w_last;
  logic [mwf_pkg::ROW_W-1:0] h_last;
  logic                      fire, end_row, end_frame, emit;

  // stage a: line store read in flight
  logic                      a_valid_q;
  mwf_pkg::pix_t             a_px_q;
  logic [AW-1:0]             a_addr_q;
  logic                      a_emit_q, a_last_q;
  logic [mwf_pkg::ROW_W-1:0] a_row_q;
  logic [mwf_pkg::COL_W-1:0] a_col_q;
  mwf_pkg::pix_t             up_rd_q, lo_rd_q;
  logic                      fwd_q;
  mwf_pkg::pix_t             fw_up_q, fw_lo_q;

  mwf_pkg::pix_t             up_eff, lo_eff;
  mwf_pkg::win_t             window_q, window_d;

  assign fire = pix_if.valid && pix_if.ready;

  // credit check: the item in stage a may still land in the queue
  assign pix_if.ready = (CW'(q_count_i) + CW'(a_valid_q)) < CW'(mwf_pkg::Q_DEPTH);

  always_comb begin
    cur_col = pix_if.frame_start ? '0 : col_q;
    cur_row = pix_if.frame_start ? '0 : row_q;

    if (32'(cur_col) >= MAX_WIDTH) begin
      addr = AW'(MAX_WIDTH - 1);
    end else begin
      addr = AW'(cur_col);
    end

    if (32'(image_width_i) < mwf_pkg::MIN_SIZE) begin
      w_last = mwf_pkg::HGT_W'(mwf_pkg::MIN_SIZE - 1);
    end else if (32'(image_width_i) > MAX_WIDTH) begin
      w_last = mwf_pkg::HGT_W'(MAX_WIDTH - 1);
    end else begin
      w_last = mwf_pkg::HGT_W'(image_width_i) - 1'b1;
    end

    if (32'(image_height_i) < mwf_pkg::MIN_SIZE) begin
      h_last = mwf_pkg::ROW_W'(mwf_pkg::MIN_SIZE - 1);
    end else if (32'(image_height_i) > mwf_pkg::MAX_HEIGHT) begin
      h_last = mwf_pkg::ROW_W'(mwf_pkg::MAX_HEIGHT - 1);
    end else begin
      h_last = mwf_pkg::ROW_W'(image_height_i - 1'b1);
    end

    end_row   = mwf_pkg::HGT_W'(cur_col) >= w_last;
    end_frame = end_row && (cur_row >= h_last);
    emit      = (32'(cur_row) >= mwf_pkg::WIN - 1) && (32'(cur_col) >= mwf_pkg::WIN - 1);

    if (end_row) begin
      col_d = '0;
      row_d = end_frame ? '0 : cur_row + 1'b1;
    end else begin
      col_d = cur_col + 1'b1;
      row_d = cur_row;
    end
  end

  // back-to-back hit on the same column sees the values being written now
  assign up_eff = fwd_q ? fw_up_q : up_rd_q;
  assign lo_eff = fwd_q ? fw_lo_q : lo_rd_q;

  always_comb begin
    for (int r = 0; r < mwf_pkg::WIN; r++) begin
      for (int c = 0; c < mwf_pkg::WIN - 1; c++) begin
        window_d[r*mwf_pkg::WIN + c] = window_q[r*mwf_pkg::WIN + c + 1];
      end
    end
    window_d[mwf_pkg::WIN - 1]       = up_eff;
    window_d[2*mwf_pkg::WIN - 1]     = lo_eff;
    window_d[mwf_pkg::WIN_N - 1]     = a_px_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
      window_q  <= '0;
    end else begin
      a_valid_q <= fire;
      if (fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (a_valid_q) begin
        window_q <= window_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      a_px_q   <= pix_if.pixel;
      a_addr_q <= addr;
      a_emit_q <= emit;
      a_last_q <= end_frame;
      a_row_q  <= cur_row;
      a_col_q  <= cur_col;
      fwd_q    <= a_valid_q && (addr == a_addr_q);
      fw_up_q  <= lo_eff;
      fw_lo_q  <= a_px_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      up_rd_q <= upper_mem[addr];
    end
    if (a_valid_q) begin
      upper_mem[a_addr_q] <= lo_eff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      lo_rd_q <= lower_mem[addr];
    end
    if (a_valid_q) begin
      lower_mem[a_addr_q] <= a_px_q;
    end
  end

  assign q_push_o        = a_valid_q && a_emit_q;
  assign q_entry_o.win   = window_d;
  assign q_entry_o.row   = a_row_q - 1'b1;
  assign q_entry_o.col   = a_col_q - 1'b1;
  assign q_entry_o.last  = a_last_q;

endmodule

// ===== hw/rtl/mwf_queue.sv =====
module mwf_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  mwf_pkg::entry_t             entry_i,
  input  logic                        pop_i,
  output logic                        valid_o,
  output mwf_pkg::entry_t             head_o,
  output logic [mwf_pkg::Q_CNT_W-1:0] count_o
);

  mwf_pkg::entry_t              slots_q [mwf_pkg::Q_DEPTH];
  logic [mwf_pkg::Q_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [mwf_pkg::Q_CNT_W-1:0]  count_q;
  logic                         do_pop;

  assign valid_o = count_q != '0;
  assign head_o  = slots_q[rd_ptr_q];
  assign count_o = count_q;
  assign do_pop  = pop_i && valid_o;

  // the front never pushes into a full queue, it holds back on credits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== hw/rtl/mwf_median.sv =====
module mwf_median (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  mwf_pkg::entry_t entry_i,
  output logic            ready_o,
  mwf_res_if.source       res_if
);

  typedef struct packed {
    logic [mwf_pkg::ROW_W-1:0] row;
    logic [mwf_pkg::COL_W-1:0] col;
    logic                      last;
  } tag_t;

  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_rdy, s2_rdy, s3_rdy;

  mwf_pkg::tri_t [mwf_pkg::WIN-1:0] s1_rows_q;
  tag_t                             s1_tag_q, s2_tag_q, s3_tag_q;
  mwf_pkg::pix_t                    s2_lo_q, s2_mid_q, s2_hi_q;
  mwf_pkg::pix_t                    s3_med_q;

  assign s3_rdy  = !s3_v_q || res_if.ready;
  assign s2_rdy  = !s2_v_q || s3_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign ready_o = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= valid_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  // rows sorted, then max of lows, median of mids, min of highs, median of those
  always_ff @(posedge clk_i) begin
    if (s1_rdy && valid_i) begin
      for (int r = 0; r < mwf_pkg::WIN; r++) begin
        s1_rows_q[r] <= mwf_pkg::sort3(entry_i.win[r*mwf_pkg::WIN],
                                       entry_i.win[r*mwf_pkg::WIN + 1],
                                       entry_i.win[r*mwf_pkg::WIN + 2]);
      end
      s1_tag_q <= '{row: entry_i.row, col: entry_i.col, last: entry_i.last};
    end
    if (s2_rdy && s1_v_q) begin
      s2_lo_q  <= mwf_pkg::max3(s1_rows_q[0].lo, s1_rows_q[1].lo, s1_rows_q[2].lo);
      s2_mid_q <= mwf_pkg::med3(s1_rows_q[0].mid, s1_rows_q[1].mid, s1_rows_q[2].mid);
      s2_hi_q  <= mwf_pkg::min3(s1_rows_q[0].hi, s1_rows_q[1].hi, s1_rows_q[2].hi);
      s2_tag_q <= s1_tag_q;
    end
    if (s3_rdy && s2_v_q) begin
      s3_med_q <= mwf_pkg::med3(s2_lo_q, s2_mid_q, s2_hi_q);
      s3_tag_q <= s2_tag_q;
    end
  end

  assign res_if.valid        = s3_v_q;
  assign res_if.out_row      = s3_tag_q.row;
  assign res_if.out_col      = s3_tag_q.col;
  assign res_if.median_value = s3_med_q;
  assign res_if.frame_last   = s3_tag_q.last;

endmodule

// ===== hw/rtl/median_window_filter.sv =====
// Streaming 3x3 median filter for 8-bit grayscale frames sent in raster order. Image width
// (register 0) and height (register 1) are clamped to 3..MAX_WIDTH and 3..4096; write them
// only while the block is idle. frame_start on a pixel restarts the position counters, and
// after the last pixel of a frame the counters wrap by themselves. Only interior positions
// produce a result, carrying row, column and the median of the neighbourhood; border pixels
// are left to the consumer. The block takes one pixel per clock: the two line stores are
// read once and written once per pixel, and the median tree is a three-stage pipeline. A
// result passes the front end's read stage, the queue and the median stages in turn. A
// four-entry queue sits between the line-store front end and the median pipeline, and the
// input drops ready only once the queue runs out of room while the output is held off.
module median_window_filter #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [0:0]                cfg_idx_i,
  input  logic [mwf_pkg::CFG_W-1:0] cfg_data_i,
  mwf_pix_if.sink                   pix_if,
  mwf_res_if.source                 res_if
);

  logic [mwf_pkg::WID_W-1:0]   width_q;
  logic [mwf_pkg::HGT_W-1:0]   height_q;
  logic                        q_push, q_valid, q_pop;
  mwf_pkg::entry_t             q_entry, q_head;
  logic [mwf_pkg::Q_CNT_W-1:0] q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= mwf_pkg::WIDTH_RST;
      height_q <= mwf_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (mwf_pkg::cfg_idx_e'(cfg_idx_i))
        mwf_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[mwf_pkg::WID_W-1:0];
        mwf_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mwf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_if         (pix_if),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .q_count_i      (q_count),
    .q_push_o       (q_push),
    .q_entry_o      (q_entry)
  );

  mwf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head),
    .count_o (q_count)
  );

  mwf_median u_median (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .entry_i (q_head),
    .ready_o (q_pop),
    .res_if  (res_if)
  );

endmodule

// ===== hw/rtl/mwf_checker.sv =====
module mwf_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [mwf_pkg::ROW_W-1:0] out_row_i,
  input logic [mwf_pkg::COL_W-1:0] out_col_i,
  input logic [mwf_pkg::PIX_W-1:0] median_value_i,
  input logic                      frame_last_i
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_row_i) && $stable(out_col_i) && $stable(median_value_i)
      && $stable(frame_last_i))
    else $error("stalled result changed");

  // only interior positions come out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_row_i != '0 && out_col_i != '0
      && out_row_i != '1 && out_col_i != '1)
    else $error("border position emitted");

endmodule

bind median_window_filter mwf_checker u_mwf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (res_if.valid),
  .out_ready_i    (res_if.ready),
  .out_row_i      (res_if.out_row),
  .out_col_i      (res_if.out_col),
  .median_value_i (res_if.median_value),
  .frame_last_i   (res_if.frame_last)
);

// ===== bench/median_window_filter_tb.sv =====
`timescale 1ns / 100ps

module median_window_filter_tb;

  localparam int unsigned MAX_W         = 1024;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 720;
  localparam int unsigned SHOWN_ERRORS  = 20;

  typedef struct packed {
    logic [mwf_pkg::ROW_W-1:0] row;
    logic [mwf_pkg::COL_W-1:0] col;
    mwf_pkg::pix_t             median;
    logic                      last;
  } median_res_t;

  typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;
  typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_FEW} pix_style_e;

  // mirror of the filter: line stores, window, position counters and size registers
  class median_mirror;
    mwf_pkg::pix_t             upper_line[MAX_W];
    mwf_pkg::pix_t             lower_line[MAX_W];
    mwf_pkg::pix_t             win[mwf_pkg::WIN_N];
    logic [mwf_pkg::ROW_W-1:0] row_pos;
    logic [mwf_pkg::COL_W-1:0] col_pos;
    logic [mwf_pkg::WID_W-1:0] width_reg;
    logic [mwf_pkg::HGT_W-1:0] height_reg;
    median_res_t               pending_medians[$];
    int unsigned               errors;
    int unsigned               checked;
    int unsigned               frame_ends;

    function new();
      foreach (upper_line[i]) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      row_pos    = '0;
      col_pos    = '0;
      width_reg  = mwf_pkg::WIDTH_RST;
      height_reg = mwf_pkg::HEIGHT_RST;
      errors     = 0;
      checked    = 0;
      frame_ends = 0;
    endfunction

    function void write_reg(mwf_pkg::cfg_idx_e idx, logic [mwf_pkg::CFG_W-1:0] data);
      case (idx)
        mwf_pkg::CFG_WIDTH:  width_reg = data[mwf_pkg::WID_W-1:0];
        mwf_pkg::CFG_HEIGHT: height_reg = data[mwf_pkg::HGT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg < mwf_pkg::MIN_SIZE) return mwf_pkg::MIN_SIZE;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < mwf_pkg::MIN_SIZE) return mwf_pkg::MIN_SIZE;
      if (height_reg > mwf_pkg::MAX_HEIGHT) return mwf_pkg::MAX_HEIGHT;
      return height_reg;
    endfunction

    function bit at_boundary();
      return (row_pos == '0) && (col_pos == '0);
    endfunction

    function mwf_pkg::pix_t window_median();
      mwf_pkg::pix_t s[mwf_pkg::WIN_N];
      mwf_pkg::pix_t t;
      s = win;
      for (int i = 0; i < mwf_pkg::WIN_N - 1; i++) begin
        for (int j = 0; j < mwf_pkg::WIN_N - 1 - i; j++) begin
          if (s[j] > s[j+1]) begin
            t      = s[j];
            s[j]   = s[j+1];
            s[j+1] = t;
          end
        end
      end
      return s[(mwf_pkg::WIN_N - 1) / 2];
    endfunction

    function void take_pixel(mwf_pkg::pix_t px, bit fs);
      int unsigned   w;
      int unsigned   h;
      mwf_pkg::pix_t up;
      mwf_pkg::pix_t lo;
      bit            end_row;
      bit            end_frame;
      median_res_t   res;
      w = eff_width();
      h = eff_height();
      if (fs) begin
        row_pos = '0;
        col_pos = '0;
      end
      up = upper_line[col_pos];
      lo = lower_line[col_pos];
      upper_line[col_pos] = lo;
      lower_line[col_pos] = px;
      for (int r = 0; r < mwf_pkg::WIN; r++) begin
        for (int c = 0; c < mwf_pkg::WIN - 1; c++)
          win[r*mwf_pkg::WIN+c] = win[r*mwf_pkg::WIN+c+1];
      end
      win[mwf_pkg::WIN-1]   = up;
      win[2*mwf_pkg::WIN-1] = lo;
      win[3*mwf_pkg::WIN-1] = px;
      end_row   = (col_pos >= w - 1);
      end_frame = end_row && (row_pos >= h - 1);
      if (row_pos >= mwf_pkg::WIN - 1 && col_pos >= mwf_pkg::WIN - 1) begin
        res.row    = row_pos - 1'b1;
        res.col    = col_pos - 1'b1;
        res.median = window_median();
        res.last   = end_frame;
        pending_medians.insert(pending_medians.size(), res);
      end
      if (end_row) begin
        col_pos = '0;
        row_pos = end_frame ? '0 : row_pos + 1'b1;
      end else begin
        col_pos = col_pos + 1'b1;
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= SHOWN_ERRORS) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task check_median(logic [mwf_pkg::ROW_W-1:0] r, logic [mwf_pkg::COL_W-1:0] c,
                      mwf_pkg::pix_t m, logic l);
      median_res_t want;
      if (pending_medians.size() == 0) begin
        report($sformatf("result at row %0d col %0d with nothing pending", r, c));
        return;
      end
      want = pending_medians.pop_front();
      checked++;
      if (want.last) frame_ends++;
      if (r !== want.row)
        report($sformatf("out_row %0d, wanted %0d", r, want.row));
      if (c !== want.col)
        report($sformatf("out_col %0d, wanted %0d (row %0d)", c, want.col, want.row));
      if (m !== want.median)
        report($sformatf("median %0d, wanted %0d at row %0d col %0d",
                         m, want.median, want.row, want.col));
      if (l !== want.last)
        report($sformatf("frame_last %0b, wanted %0b at row %0d col %0d",
                         l, want.last, want.row, want.col));
    endtask
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we;
  mwf_pkg::cfg_idx_e         cfg_idx;
  logic [mwf_pkg::CFG_W-1:0] cfg_data;

  mwf_pix_if pix_bus ();
  mwf_res_if res_bus ();

  median_window_filter #(
    .MAX_WIDTH (MAX_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_if     (pix_bus),
    .res_if     (res_bus)
  );

  median_mirror mirror = new();

  int unsigned burst_left      = 0;
  bit          restart_pending = 1'b0;
  int unsigned pixels_sent     = 0;
  int unsigned reg_writes      = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver: ready pattern switches at random among open, mostly ready, sparse and periodic
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_tick = 0;

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(50, 400);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   res_bus.ready <= 1'b1;
      RX_MOSTLY: res_bus.ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: res_bus.ready <= ($urandom_range(0, 3) == 0);
      default:   res_bus.ready <= ((rx_tick % 8) >= 3);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready)
      mirror.check_median(res_bus.out_row, res_bus.out_col, res_bus.median_value,
                          res_bus.frame_last);
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout: %0d cycles without a transaction", QUIET_LIMIT);
    $display("** median_window_filter: FAILED **");
    $finish;
  end

  function automatic mwf_pkg::pix_t pick_pixel(pix_style_e style);
    case (style)
      PIX_EXTREME: return $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 2))
                                               : 8'($urandom_range(0, 2));
      PIX_FEW:     return 8'($urandom_range(0, 3) * 85);
      default:     return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // all calls start and end on a falling edge
  task automatic send_pixel(input mwf_pkg::pix_t px, input bit fs);
    int unsigned gap;
    int unsigned roll;
    bit          start;
    start = fs | restart_pending;
    restart_pending = 1'b0;
    if (burst_left == 0) begin
      roll = $urandom_range(0, 9);
      if (roll < 6) gap = 0;
      else if (roll < 9) gap = $urandom_range(1, 3);
      else gap = $urandom_range(4, 20);
      if (gap != 0) begin
        pix_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    pix_bus.valid       <= 1'b1;
    pix_bus.pixel       <= px;
    pix_bus.frame_start <= start;
    do @(posedge clk_i); while (!pix_bus.ready);
    mirror.take_pixel(px, start);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    pix_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (mirror.pending_medians.size() != 0) @(negedge clk_i);
    // border pixels may still be in flight with no result to wait for
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input mwf_pkg::cfg_idx_e idx,
                           input logic [mwf_pkg::CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    mirror.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    reg_writes++;
  endtask

  task automatic set_size(input logic [mwf_pkg::CFG_W-1:0] wdata,
                          input logic [mwf_pkg::CFG_W-1:0] hdata);
    int unsigned old_w;
    drain();
    old_w = mirror.eff_width();
    write_reg(mwf_pkg::CFG_WIDTH, wdata);
    write_reg(mwf_pkg::CFG_HEIGHT, hdata);
    // a wider row mid-frame would read line store entries never filled
    if (!mirror.at_boundary() && mirror.eff_width() > old_w) restart_pending = 1'b1;
  endtask

  task automatic finish_frame(input pix_style_e style);
    while (!mirror.at_boundary()) send_pixel(pick_pixel(style), 1'b0);
  endtask

  task automatic random_size();
    int unsigned               pick;
    logic [mwf_pkg::CFG_W-1:0] wd;
    logic [mwf_pkg::CFG_W-1:0] hd;
    pick = $urandom_range(0, 49);
    if (pick < 4) begin
      wd = mwf_pkg::CFG_W'($urandom_range(0, 2));
      hd = mwf_pkg::CFG_W'($urandom_range(0, 2));
    end else if (pick < 8) begin
      wd = mwf_pkg::CFG_W'($urandom_range(13, 64));
      hd = mwf_pkg::CFG_W'($urandom_range(3, 5));
    end else begin
      wd = mwf_pkg::CFG_W'($urandom_range(3, 12));
      hd = mwf_pkg::CFG_W'($urandom_range(3, 9));
    end
    // bits above the width register are dropped by the block
    wd[mwf_pkg::CFG_W-1:mwf_pkg::WID_W] = 2'($urandom_range(0, 3));
    set_size(wd, hd);
  endtask

  initial begin
    int unsigned random_base;
    int unsigned kind;
    int unsigned n;
    pix_style_e  style;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = mwf_pkg::CFG_WIDTH;
    cfg_data            = '0;
    pix_bus.valid       = 1'b0;
    pix_bus.pixel       = '0;
    pix_bus.frame_start = 1'b0;
    res_bus.ready       = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    set_size(mwf_pkg::CFG_W'(3), mwf_pkg::CFG_W'(3));
    // smallest frame, alternating full-scale pixels
    for (int i = 0; i < 9; i++) send_pixel((i % 2 == 0) ? 8'hFF : 8'h00, i == 0);
    // next frame follows with no frame start
    for (int i = 0; i < 9; i++) send_pixel((i % 2 == 0) ? 8'h00 : 8'hFF, 1'b0);
    // frame abandoned after two pixels and restarted
    send_pixel(8'hFF, 1'b1);
    send_pixel(8'hFF, 1'b0);
    for (int i = 0; i < 9; i++) send_pixel(8'(i * 31), i == 0);

    // sizes below range and masked width bits clamp to the minimum
    set_size(mwf_pkg::CFG_W'(13'h1801), mwf_pkg::CFG_W'(0));
    send_pixel(pick_pixel(PIX_UNIFORM), 1'b1);
    finish_frame(PIX_UNIFORM);

    // shrink width then height in the middle of a frame
    set_size(mwf_pkg::CFG_W'(6), mwf_pkg::CFG_W'(8));
    send_pixel(pick_pixel(PIX_UNIFORM), 1'b1);
    repeat (15) send_pixel(pick_pixel(PIX_UNIFORM), 1'b0);
    set_size(mwf_pkg::CFG_W'(4), mwf_pkg::CFG_W'(8));
    repeat (8) send_pixel(pick_pixel(PIX_FEW), 1'b0);
    set_size(mwf_pkg::CFG_W'(4), mwf_pkg::CFG_W'(4));
    finish_frame(PIX_UNIFORM);

    random_base = pixels_sent;
    while (pixels_sent - random_base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) random_size();
      style = pix_style_e'($urandom_range(0, 2));
      kind  = $urandom_range(0, 19);
      if (kind < 3) begin
        // broken frame with stray frame starts
        n = $urandom_range(1, mirror.eff_width() * mirror.eff_height());
        repeat (n) send_pixel(pick_pixel(style), $urandom_range(0, 15) == 0);
      end else begin
        send_pixel(pick_pixel(style), mirror.at_boundary() ? 1'($urandom_range(0, 1)) : 1'b1);
        if (kind == 3) begin
          // hold the sender until every pending result is out
          repeat ($urandom_range(0, 2 * mirror.eff_width())) send_pixel(pick_pixel(style), 1'b0);
          drain();
        end
        finish_frame(style);
      end
    end

    drain();
    if (mirror.pending_medians.size() != 0)
      mirror.report($sformatf("%0d results never arrived", mirror.pending_medians.size()));
    $display("covered %0d pixels over %0d register writes: %0d medians checked, %0d frame ends",
             pixels_sent, reg_writes, mirror.checked, mirror.frame_ends);
    if (mirror.errors == 0) begin
      $display("** median_window_filter: PASSED **");
    end else begin
      $display("%0d mismatches", mirror.errors);
      $display("** median_window_filter: FAILED **");
    end
    $finish;
  end

endmodule

// ===== median_window_filter.f =====
hw/rtl/mwf_pkg.sv
hw/rtl/mwf_intf.sv
hw/rtl/mwf_front.sv
hw/rtl/mwf_queue.sv
hw/rtl/mwf_median.sv
hw/rtl/median_window_filter.sv
hw/rtl/mwf_checker.sv
bench/median_window_filter_tb.sv
